// ===== hw/rtl/lzss4k_pkg.sv =====
// Shared types and constants for the 4 KiB window LZSS decompressor.
// No dependencies; imported by lzss4k_ctrl, lzss4k_dp and the top level.
package lzss4k_pkg;

	localparam int WIN_SIZE   = 4096;
	localparam int WIN_AW     = $clog2(WIN_SIZE);
	localparam int CNT_W      = WIN_AW + 1;
	localparam int MATCH_BIAS = 2;
	localparam int LEN_MAX    = 15 + MATCH_BIAS + 1;
	localparam int REM_W      = $clog2(LEN_MAX + 1);
	localparam logic [8:0] FLAG_MARK = 9'h100;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_req_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_count;   // new stream: restart produced count
		logic hi_load;     // capture first byte of a pair
		logic pair_start;  // issue first history read of a copy
		logic lit_emit;    // emit the input byte
		logic copy_emit;   // emit one copied byte, issue next read
		logic last;        // emitted byte ends this request's run
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       out_free;
		logic [3:0] len_nib;
	} sts_t;

endpackage

// ===== hw/rtl/lzss4k_ctrl.sv =====
// Controller for the LZSS decompressor: flag tracking, unit phase, copy length.
// Depends on lzss4k_pkg; drives lzss4k_dp through cmd_t and reads sts_t.
module lzss4k_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lzss4k_pkg::in_req_t  in_req,
	output lzss4k_pkg::cmd_t     cmd,
	input  lzss4k_pkg::sts_t     sts
);
	import lzss4k_pkg::*;

	typedef enum logic [1:0] {
		ST_FLAG,
		ST_UNIT,
		ST_PAIR_LO,
		ST_COPY
	} state_t;

	state_t           state_q;
	logic [8:0]       flag_q;
	logic [REM_W-1:0] rem_q;
	logic             accept;
	logic [8:0]       flag_next;

	assign in_ready  = (state_q != ST_COPY) && sts.out_free;
	assign accept    = in_valid && in_ready;
	assign flag_next = flag_q >> 1;

	always_comb begin
		cmd = '0;
		if (accept) begin
			if (in_req.stream_start) begin
				cmd.clr_count = 1'b1;
			end else begin
				unique case (state_q)
					ST_UNIT: begin
						cmd.lit_emit = flag_q[0];
						cmd.hi_load  = !flag_q[0];
						cmd.last     = flag_q[0];
					end
					ST_PAIR_LO: cmd.pair_start = 1'b1;
					default: ;
				endcase
			end
		end else if (state_q == ST_COPY && sts.out_free) begin
			cmd.copy_emit = 1'b1;
			cmd.last      = (rem_q == REM_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FLAG;
			flag_q  <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			if (in_req.stream_start || state_q == ST_FLAG) begin
				flag_q  <= FLAG_MARK | {1'b0, in_req.in_byte};
				state_q <= ST_UNIT;
			end else begin
				unique case (state_q)
					ST_UNIT: begin
						if (flag_q[0]) begin
							// literal: advance to the next unit
							flag_q  <= flag_next;
							state_q <= (flag_next > 9'd1) ? ST_UNIT : ST_FLAG;
						end else begin
							state_q <= ST_PAIR_LO;
						end
					end
					ST_PAIR_LO: begin
						rem_q   <= REM_W'(sts.len_nib) + REM_W'(MATCH_BIAS + 1);
						state_q <= ST_COPY;
					end
					default: state_q <= ST_FLAG;
				endcase
			end
		end else if (cmd.copy_emit) begin
			rem_q <= rem_q - REM_W'(1);
			if (cmd.last) begin
				flag_q  <= flag_next;
				state_q <= (flag_next > 9'd1) ? ST_UNIT : ST_FLAG;
			end
		end
	end

endmodule

// ===== hw/rtl/lzss4k_dp.sv =====
// Datapath for the LZSS decompressor: history memory, write pointer,
// produced count, distance and the output register. Depends on lzss4k_pkg.
module lzss4k_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzss4k_pkg::in_req_t  in_req,
	input  lzss4k_pkg::cmd_t     cmd,
	output lzss4k_pkg::sts_t     sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzss4k_pkg::out_req_t out_req
);
	import lzss4k_pkg::*;

	logic [7:0]        hist_mem [WIN_SIZE];
	logic [7:0]        rd_q;
	logic [7:0]        hi_q;
	logic [WIN_AW-1:0] dist_q;
	logic [WIN_AW-1:0] wp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	out_req_t          out_q;

	logic [WIN_AW-1:0] dist_new;
	logic [WIN_AW-1:0] rd_addr;
	logic              rd_en;
	logic              wr_en;
	logic              copy_zero;
	logic [7:0]        wr_data;

	assign dist_new  = {hi_q[3:0], in_req.in_byte};
	assign rd_en     = cmd.pair_start || cmd.copy_emit;
	// next copy byte reads one slot past the byte written this cycle
	assign rd_addr   = cmd.pair_start ? (wp_q - dist_new) : (wp_q + WIN_AW'(1) - dist_q);
	assign wr_en     = cmd.lit_emit || cmd.copy_emit;
	// zero before stream start, and for the never-encoded distance zero
	assign copy_zero = (dist_q == '0) || (cnt_q < {1'b0, dist_q});
	assign wr_data   = cmd.lit_emit ? in_req.in_byte : (copy_zero ? 8'h00 : rd_q);

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.len_nib  = hi_q[7:4];
	assign out_valid    = out_valid_q;
	assign out_req      = out_q;

	// write-first: a read of the slot being written sees the new byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wp_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= (wr_en && rd_addr == wp_q) ? wr_data : hist_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hi_load) begin
			hi_q <= in_req.in_byte;
		end
		if (cmd.pair_start) begin
			dist_q <= dist_new;
		end
		if (wr_en) begin
			out_q.out_byte <= wr_data;
			out_q.run_last <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_count) begin
				cnt_q <= '0;
			end else if (wr_en && cnt_q != CNT_W'(WIN_SIZE)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (wr_en) begin
				wp_q        <= wp_q + WIN_AW'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/lzss_decompressor_4k_window.sv =====
// LZSS decompressor, 4096-byte history. Flag bytes and first pair bytes give no output.
// A literal appears on the output in the cycle after its request is taken.
// A copy reads history into a register, then the output register: one byte per cycle
// while output is free, paced by the single history port; no request taken meanwhile.
// Reset clears control, pointer and count; history stays undefined until written.
module lzss_decompressor_4k_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lzss4k_pkg::in_req_t  in_req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzss4k_pkg::out_req_t out_req
);
	import lzss4k_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lzss4k_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.cmd      (cmd),
		.sts      (sts)
	);

	lzss4k_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_req    (in_req),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_req   (out_req)
	);

endmodule

// ===== sim/lzss_decompressor_4k_window_tb.sv =====
// Self-checking testbench for lzss_decompressor_4k_window: compressed streams in, bytes checked.
// Holds its own LZSS expander as the predictor; depends on lzss4k_pkg and the top level RTL.
// Random gaps on both sides, plus one long output hold-off to back up the input.
module lzss_decompressor_4k_window_tb;
	import lzss4k_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 320;
	localparam int HOLD_AFTER = 90;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [1:0] {
		EXPECT_FLAG    = 2'd0,
		EXPECT_UNIT    = 2'd1,
		EXPECT_PAIR_LO = 2'd2
	} parse_t;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	in_req_t  in_req;
	logic     out_valid;
	logic     out_ready;
	out_req_t out_req;

	// predictor state
	logic [7:0]       win_mem [WIN_SIZE];
	logic [CNT_W-1:0] win_fill;
	logic [WIN_AW-1:0] win_wr;
	logic [8:0]       flag_bits;
	parse_t           parse_st;
	logic [7:0]       pair_hi;

	in_req_t  comp_stream [$];
	out_req_t pending_bytes [$];

	bit in_took;
	bit out_took;
	bit in_calm;
	bit out_calm;
	bit hold_done;
	int in_gap;
	int out_wait;
	int hold_cnt;
	int inputs_taken;
	int cycles;
	int errors;

	// {stream_start, in_byte}
	logic [8:0] opening [0:22] = '{
		9'h155, 9'h000, 9'h000, 9'h001, 9'h0FF, 9'h0F0, 9'h000, 9'h080,
		9'h0FF, 9'h0FF, 9'h07F, 9'h020, 9'h005, 9'h000, 9'h030, 9'h02B,
		9'h1FF, 9'h05A, 9'h0A5, 9'h100, 9'h01F, 9'h101, 9'h03C
	};

	lzss_decompressor_4k_window DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_req   (out_req)
	);

	always #5 clk = ~clk;

	task automatic put_byte(input logic [7:0] v, input logic last);
		out_req_t o;
		o.out_byte = v;
		o.run_last = last;
		pending_bytes.push_back(o);
		win_mem[win_wr] = v;
		win_wr = win_wr + 1'b1;
		if (win_fill < WIN_SIZE)
			win_fill = win_fill + 1'b1;
	endtask

	task automatic advance_unit();
		flag_bits = flag_bits >> 1;
		parse_st = (flag_bits > 9'd1) ? EXPECT_UNIT : EXPECT_FLAG;
	endtask

	task automatic expand_byte(input in_req_t r);
		logic [WIN_AW-1:0] dist_v;
		logic [WIN_AW-1:0] rd;
		logic [7:0]        v;
		int                len;
		int                k;
		if (r.stream_start) begin
			parse_st = EXPECT_FLAG;
			win_fill = '0;
			flag_bits = '0;
			pair_hi = '0;
		end
		case (parse_st)
			EXPECT_UNIT: begin
				if (flag_bits[0]) begin
					put_byte(r.in_byte, 1'b1);
					advance_unit();
				end else begin
					pair_hi = r.in_byte;
					parse_st = EXPECT_PAIR_LO;
				end
			end
			EXPECT_PAIR_LO: begin
				dist_v = {pair_hi[3:0], r.in_byte};
				len = int'(pair_hi[7:4]) + MATCH_BIAS + 1;
				for (k = 0; k < len; k++) begin
					rd = win_wr - dist_v;
					// zero for distance zero and for reach before the stream start
					v = (dist_v != 0 && win_fill >= dist_v) ? win_mem[rd] : 8'h00;
					put_byte(v, k == len - 1);
				end
				advance_unit();
			end
			default: begin
				flag_bits = FLAG_MARK | {1'b0, r.in_byte};
				parse_st = EXPECT_UNIT;
			end
		endcase
	endtask

	task automatic push_comp(input logic [7:0] b, input logic start);
		in_req_t r;
		r.in_byte = b;
		r.stream_start = start;
		comp_stream.push_back(r);
	endtask

	// Well-formed stream; heavy favors long copies, cut drops the tail at a random unit.
	task automatic gen_stream(input int groups, input bit heavy, input bit cut);
		int          made;
		int          unit;
		int          cut_at;
		int          sel;
		int          g;
		int          b;
		logic [7:0]  flags;
		logic [3:0]  nib;
		logic [11:0] dist_v;
		made = 0;
		unit = 0;
		cut_at = cut ? $urandom_range(0, groups * 8 - 1) : -1;
		for (g = 0; g < groups; g++) begin
			if (heavy) begin
				for (b = 0; b < 8; b++)
					flags[b] = ($urandom_range(0, 15) == 0);
			end else begin
				flags = 8'($urandom_range(0, 255));
			end
			push_comp(flags, g == 0);
			for (b = 0; b < 8; b++) begin
				if (unit == cut_at && flags[b])
					return;
				if (flags[b]) begin
					push_comp(8'($urandom_range(0, 255)), 1'b0);
					made++;
				end else begin
					nib = (heavy && $urandom_range(0, 7) != 0) ? 4'hF :
						4'($urandom_range(0, 15));
					sel = $urandom_range(0, 31);
					if (sel == 0)
						dist_v = '0;
					else if (sel < 5 && made < WIN_SIZE - 1)
						dist_v = 12'($urandom_range(made + 1, WIN_SIZE - 1));
					else if (sel < 11 || made == 0)
						dist_v = 12'($urandom_range(1, 3));
					else
						dist_v = 12'($urandom_range(1,
							(made < WIN_SIZE - 1) ? made : WIN_SIZE - 1));
					push_comp({nib, dist_v[11:8]}, 1'b0);
					// stop between the two bytes of the pair
					if (unit == cut_at)
						return;
					push_comp(dist_v[7:0], 1'b0);
					made += int'(nib) + MATCH_BIAS + 1;
				end
				unit++;
			end
		end
	endtask

	// sample both channels, predict, check
	always @(posedge clk) begin
		out_req_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else if (arst_n) begin
			in_took = in_valid && in_ready;
			out_took = out_valid && out_ready;
			if (in_took) begin
				expand_byte(in_req);
				inputs_taken++;
			end
			if (out_took) begin
				if (pending_bytes.size() == 0) begin
					$display("%0t: unexpected byte, expected none, actual out_byte %h run_last %b",
						$time, out_req.out_byte, out_req.run_last);
					errors++;
				end else begin
					want = pending_bytes.pop_front();
					if (out_req.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %h actual %h",
							$time, want.out_byte, out_req.out_byte);
						errors++;
					end
					if (out_req.run_last !== want.run_last) begin
						$display("%0t: run_last expected %b actual %b",
							$time, want.run_last, out_req.run_last);
						errors++;
					end
				end
			end
		end
	end

	// sender: hold the request until taken, then wait a drawn gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_took) begin
				in_valid <= 1'b1;
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (comp_stream.size() != 0) begin
				in_valid <= 1'b1;
				in_req <= comp_stream.pop_front();
				if ($urandom_range(0, 39) == 0)
					in_calm = !in_calm;
				in_gap = in_calm ? 0 : $urandom_range(0, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, one long hold-off while input keeps coming
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				out_ready <= 1'b0;
				hold_cnt--;
			end else if (!hold_done && inputs_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_cnt = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				if (out_took) begin
					if ($urandom_range(0, 29) == 0)
						out_calm = !out_calm;
					out_wait = out_calm ? 0 : $urandom_range(0, 9);
				end
				if (out_wait > 0) begin
					out_ready <= 1'b0;
					out_wait--;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		int sel;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		out_ready = 1'b0;
		parse_st = EXPECT_FLAG;
		win_fill = '0;
		win_wr = '0;
		flag_bits = '0;
		pair_hi = '0;

		foreach (opening[i])
			push_comp(opening[i][7:0], opening[i][8]);
		gen_stream(16, 1'b1, 1'b0);
		while (comp_stream.size() < RANDOM_ITEMS + 23) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				gen_stream($urandom_range(1, 4), 1'b0, 1'b0);
			end else if (sel < 8) begin
				gen_stream($urandom_range(1, 3), 1'b0, 1'b1);
			end else begin
				repeat ($urandom_range(1, 12))
					push_comp(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (comp_stream.size() != 0 || in_valid)
			@(negedge clk);
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== lzss_decompressor_4k_window.f =====
hw/rtl/lzss4k_pkg.sv
hw/rtl/lzss4k_ctrl.sv
hw/rtl/lzss4k_dp.sv
hw/rtl/lzss_decompressor_4k_window.sv
sim/lzss_decompressor_4k_window_tb.sv
